@@ design/iia_pkg.sv @@
package iia_pkg;

   localparam int TYPE_BITS   = 3;
   localparam int POS_BITS    = 7;
   localparam int VALUE_BITS  = 32;
   localparam int COUNT_BITS  = 7;
   localparam int STATUS_BITS = 2;

   // Cells whose read taps are combined in one register of the read tree.
   localparam int GROUP_SIZE = 32;

   typedef enum logic [TYPE_BITS-1:0] {
      REQ_ADD_END      = 3'd0,
      REQ_ADD_START    = 3'd1,
      REQ_INSERT       = 3'd2,
      REQ_REMOVE_END   = 3'd3,
      REQ_REMOVE_START = 3'd4,
      REQ_REMOVE_AT    = 3'd5,
      REQ_READ         = 3'd6
   } req_code_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      logic insert;
      logic remove;
      logic read;
   } cell_op_type;

endpackage

@@ design/iia_req_if.sv @@
interface iia_req_if;
   logic                            valid;
   logic                            ready;
   logic [iia_pkg::TYPE_BITS-1:0]   req_type;
   logic [iia_pkg::POS_BITS-1:0]    position;
   logic [iia_pkg::VALUE_BITS-1:0]  value;

   modport source (output valid, output req_type, output position, output value,
                   input ready);
   modport sink   (input valid, input req_type, input position, input value,
                   output ready);
endinterface

@@ design/iia_rsp_if.sv @@
interface iia_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [iia_pkg::VALUE_BITS-1:0]   read_value;
   logic [iia_pkg::COUNT_BITS-1:0]   count;
   logic [iia_pkg::STATUS_BITS-1:0]  status;

   modport source (output valid, output read_value, output count, output status,
                   input ready);
   modport sink   (input valid, input read_value, input count, input status,
                   output ready);
endinterface

@@ design/indexed_insert_remove_array.sv @@
// An accepted item is registered in the group stage, then in the response stage.
// Throughput: one item per cycle while the output is not stalled; the cell row
// shifts every word in the same cycle, and the read path is a two-stage OR tree
// over groups of 32 cell taps. Reset (synchronous): clears the element count and
// both pipeline stages; cell words are not reset and are only read once written.
module indexed_insert_remove_array #(
   parameter int CAPACITY  = 64,
   parameter int WORD_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   iia_req_if.sink   req_if,
   iia_rsp_if.source rsp_if
);

   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int N_GROUPS = (CAPACITY + iia_pkg::GROUP_SIZE - 1) / iia_pkg::GROUP_SIZE;

   iia_pkg::cell_op_type op;
   iia_pkg::status_type  status;
   iia_pkg::status_type  st1_ff;
   iia_pkg::status_type  rsp_status_ff;
   logic [IDX_W-1:0]     pos;
   logic [CNT_W-1:0]     count_cur;
   logic [CNT_W-1:0]     count_next;
   logic                 accept;
   logic                 v1_ff;
   logic                 adv1;
   logic                 rsp_valid_ff;
   logic [WORD_BITS-1:0] new_word;
   logic [WORD_BITS-1:0] cell_word [CAPACITY];
   logic [WORD_BITS-1:0] tap       [CAPACITY];
   logic [WORD_BITS-1:0] grp_in    [N_GROUPS];
   logic [WORD_BITS-1:0] grp_ff    [N_GROUPS];
   logic [WORD_BITS-1:0] read_in;
   logic [iia_pkg::COUNT_BITS-1:0] cnt1_ff;
   logic [iia_pkg::COUNT_BITS-1:0] rsp_count_ff;
   logic [iia_pkg::VALUE_BITS-1:0] read_value_ff;

   assign adv1         = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = !v1_ff || adv1;
   assign accept       = req_if.valid && req_if.ready;
   assign new_word     = WORD_BITS'(req_if.value);

   iia_ctrl #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_type   (req_if.req_type),
      .position   (req_if.position),
      .op         (op),
      .pos        (pos),
      .status     (status),
      .count_cur  (count_cur),
      .count_next (count_next)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [WORD_BITS-1:0] left_word;
      logic [WORD_BITS-1:0] right_word;

      if (i == 0) begin : g_first
         assign left_word = cell_word[0];
      end else begin : g_left
         assign left_word = cell_word[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_word = cell_word[i];
      end else begin : g_right
         assign right_word = cell_word[i+1];
      end

      iia_cell #(
         .INDEX     (i),
         .IDX_W     (IDX_W),
         .WORD_BITS (WORD_BITS)
      ) u_cell (
         .clock      (clock),
         .op         (op),
         .pos        (pos),
         .new_word   (new_word),
         .left_word  (left_word),
         .right_word (right_word),
         .word_ff    (cell_word[i]),
         .rd_word    (tap[i])
      );
   end

   always_comb begin
      for (int g = 0; g < N_GROUPS; g++) begin
         grp_in[g] = '0;
      end
      for (int i = 0; i < CAPACITY; i++) begin
         grp_in[i / iia_pkg::GROUP_SIZE] = grp_in[i / iia_pkg::GROUP_SIZE] | tap[i];
      end
   end

   always_comb begin
      read_in = '0;
      for (int g = 0; g < N_GROUPS; g++) begin
         read_in = read_in | grp_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_if.ready) begin
            v1_ff <= req_if.valid;
         end
         if (adv1) begin
            rsp_valid_ff <= v1_ff;
         end
      end
      if (accept) begin
         grp_ff  <= grp_in;
         cnt1_ff <= iia_pkg::COUNT_BITS'(count_next);
         st1_ff  <= status;
      end
      if (adv1 && v1_ff) begin
         read_value_ff <= iia_pkg::VALUE_BITS'(read_in);
         rsp_count_ff  <= cnt1_ff;
         rsp_status_ff <= st1_ff;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.read_value = read_value_ff;
   assign rsp_if.count      = rsp_count_ff;
   assign rsp_if.status     = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_cur <= CNT_W'(CAPACITY))
      else $error("element count exceeds capacity");

   a_refused_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (accept && (status != iia_pkg::ST_OK)) |=> (count_cur == $past(count_cur)))
      else $error("refused item changed the element count");

   a_single_shift: assert property (@(posedge clock) disable iff (reset)
      !(op.insert && op.remove))
      else $error("insert and remove shift issued together");

   a_read_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != iia_pkg::ST_OK)) |-> (read_value_ff == '0))
      else $error("non-zero read word on a failed item");

endmodule

@@ design/iia_cell.sv @@
module iia_cell #(
   parameter int INDEX     = 0,
   parameter int IDX_W     = 6,
   parameter int WORD_BITS = 32
) (
   input  logic                 clock,
   input  iia_pkg::cell_op_type op,
   input  logic [IDX_W-1:0]     pos,
   input  logic [WORD_BITS-1:0] new_word,
   input  logic [WORD_BITS-1:0] left_word,
   input  logic [WORD_BITS-1:0] right_word,
   output logic [WORD_BITS-1:0] word_ff,
   output logic [WORD_BITS-1:0] rd_word
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [WORD_BITS-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      if (op.insert && (MY_IDX > pos)) begin
         word_in = left_word;
      end else if (op.insert && (MY_IDX == pos)) begin
         word_in = new_word;
      end else if (op.remove && (MY_IDX >= pos)) begin
         word_in = right_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign rd_word = (op.read && (MY_IDX == pos)) ? word_ff : '0;

endmodule

@@ design/iia_ctrl.sv @@
module iia_ctrl #(
   parameter int CAPACITY = 64,
   parameter int IDX_W    = 6,
   parameter int CNT_W    = 7
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [iia_pkg::TYPE_BITS-1:0]   req_type,
   input  logic [iia_pkg::POS_BITS-1:0]    position,
   output iia_pkg::cell_op_type            op,
   output logic [IDX_W-1:0]                pos,
   output iia_pkg::status_type             status,
   output logic [CNT_W-1:0]                count_cur,
   output logic [CNT_W-1:0]                count_next
);

   localparam int CMP_W = (CNT_W > iia_pkg::POS_BITS) ? CNT_W : iia_pkg::POS_BITS;

   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic [CMP_W-1:0]     cnt_x;
   logic [CMP_W-1:0]     pos_x;
   logic [CMP_W-1:0]     target;
   logic                 full;
   logic                 empty;
   logic                 grow;
   logic                 shrink;
   iia_pkg::cell_op_type op_raw;

   assign cnt_x = CMP_W'(count_ff);
   assign pos_x = CMP_W'(position);
   assign full  = (count_ff == CNT_W'(CAPACITY));
   assign empty = (count_ff == '0);

   always_comb begin
      op_raw = '0;
      target = '0;
      status = iia_pkg::ST_OK;
      grow   = 1'b0;
      shrink = 1'b0;
      case (iia_pkg::req_code_type'(req_type))
         iia_pkg::REQ_ADD_END: begin
            if (full) begin
               status = iia_pkg::ST_FULL;
            end else begin
               op_raw.insert = 1'b1;
               target        = cnt_x;
               grow          = 1'b1;
            end
         end
         iia_pkg::REQ_ADD_START: begin
            if (full) begin
               status = iia_pkg::ST_FULL;
            end else begin
               op_raw.insert = 1'b1;
               grow          = 1'b1;
            end
         end
         iia_pkg::REQ_INSERT: begin
            if (pos_x > cnt_x) begin
               status = iia_pkg::ST_RANGE;
            end else if (full) begin
               status = iia_pkg::ST_FULL;
            end else begin
               op_raw.insert = 1'b1;
               target        = pos_x;
               grow          = 1'b1;
            end
         end
         iia_pkg::REQ_REMOVE_END: begin
            if (empty) begin
               status = iia_pkg::ST_EMPTY;
            end else begin
               shrink = 1'b1;
            end
         end
         iia_pkg::REQ_REMOVE_START: begin
            if (empty) begin
               status = iia_pkg::ST_EMPTY;
            end else begin
               op_raw.remove = 1'b1;
               shrink        = 1'b1;
            end
         end
         iia_pkg::REQ_REMOVE_AT: begin
            if (pos_x >= cnt_x) begin
               status = iia_pkg::ST_RANGE;
            end else begin
               op_raw.remove = 1'b1;
               target        = pos_x;
               shrink        = 1'b1;
            end
         end
         iia_pkg::REQ_READ: begin
            if (pos_x >= cnt_x) begin
               status = iia_pkg::ST_RANGE;
            end else begin
               op_raw.read = 1'b1;
               target      = pos_x;
            end
         end
         default: begin
         end
      endcase
   end

   assign op.insert = accept & op_raw.insert;
   assign op.remove = accept & op_raw.remove;
   assign op.read   = accept & op_raw.read;
   assign pos       = IDX_W'(target);

   always_comb begin
      count_in = count_ff;
      if (accept && grow) begin
         count_in = count_ff + CNT_W'(1);
      end else if (accept && shrink) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count_cur  = count_ff;
   assign count_next = count_in;

endmodule

@@ tb/sv/insert_remove_checker.sv @@
`timescale 1ns / 1ps

module insert_remove_checker
   import iia_pkg::*;
#(
   parameter int CAPACITY  = 64,
   parameter int WORD_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   iia_req_if                    req_mon,
   iia_rsp_if                    rsp_mon,
   output logic [COUNT_BITS-1:0] held_count,
   output int                    mismatches,
   output int                    outstanding
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam logic [VALUE_BITS-1:0] WORD_MASK =
      (WORD_BITS >= VALUE_BITS) ? '1 : ((VALUE_BITS'(1) << WORD_BITS) - 1);

   typedef struct packed {
      logic [VALUE_BITS-1:0] read_value;
      logic [COUNT_BITS-1:0] count;
      status_type            status;
   } array_response_type;

   logic [VALUE_BITS-1:0] held_words [0:CAPACITY-1];
   array_response_type    predicted_responses [$];
   array_response_type    oldest;

   initial begin
      held_count  = '0;
      mismatches  = 0;
      outstanding = 0;
      for (int k = 0; k < CAPACITY; k++) begin
         held_words[k] = '0;
      end
   end

   task automatic report_mismatch(input string what, input logic [VALUE_BITS-1:0] got,
                                  input logic [VALUE_BITS-1:0] want);
      $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   function automatic status_type insert_word(input int at, input logic [VALUE_BITS-1:0] word);
      int held;
      held = int'(held_count);
      if (at > held) begin
         return ST_RANGE;
      end
      if (held >= CAPACITY) begin
         return ST_FULL;
      end
      for (int k = held; k > at; k--) begin
         held_words[k] = held_words[k-1];
      end
      held_words[at] = word & WORD_MASK;
      held_count = COUNT_BITS'(held + 1);
      return ST_OK;
   endfunction

   function automatic status_type remove_word(input int at);
      int held;
      held = int'(held_count);
      if (at >= held) begin
         return ST_RANGE;
      end
      for (int k = at; k + 1 < held; k++) begin
         held_words[k] = held_words[k+1];
      end
      held_count = COUNT_BITS'(held - 1);
      return ST_OK;
   endfunction

   function automatic array_response_type apply_request(input logic [TYPE_BITS-1:0] code,
                                                        input logic [POS_BITS-1:0] pos,
                                                        input logic [VALUE_BITS-1:0] word);
      array_response_type rsp;
      rsp.read_value = '0;
      rsp.status     = ST_OK;
      case (code)
         REQ_ADD_END: begin
            rsp.status = insert_word(int'(held_count), word);
         end
         REQ_ADD_START: begin
            rsp.status = insert_word(0, word);
         end
         REQ_INSERT: begin
            rsp.status = insert_word(int'(pos), word);
         end
         REQ_REMOVE_END: begin
            if (held_count == '0) begin
               rsp.status = ST_EMPTY;
            end else begin
               held_count = held_count - COUNT_BITS'(1);
            end
         end
         REQ_REMOVE_START: begin
            rsp.status = (held_count == '0) ? ST_EMPTY : remove_word(0);
         end
         REQ_REMOVE_AT: begin
            rsp.status = remove_word(int'(pos));
         end
         REQ_READ: begin
            if (pos < held_count && int'(pos) < CAPACITY) begin
               rsp.read_value = held_words[pos[IDX_W-1:0]];
            end else begin
               rsp.status = ST_RANGE;
            end
         end
         default: begin
         end
      endcase
      rsp.count = held_count;
      return rsp;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (predicted_responses.size() == 0) begin
               report_mismatch("unexpected item", VALUE_BITS'(rsp_mon.count), '0);
            end else begin
               oldest = predicted_responses.pop_front();
               if (rsp_mon.read_value !== oldest.read_value) begin
                  report_mismatch("read_value", rsp_mon.read_value, oldest.read_value);
               end
               if (rsp_mon.count !== oldest.count) begin
                  report_mismatch("count", VALUE_BITS'(rsp_mon.count),
                                  VALUE_BITS'(oldest.count));
               end
               if (rsp_mon.status !== oldest.status) begin
                  report_mismatch("status", VALUE_BITS'(rsp_mon.status),
                                  VALUE_BITS'(oldest.status));
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            predicted_responses.push_back(apply_request(req_mon.req_type, req_mon.position,
                                                        req_mon.value));
         end
         outstanding = predicted_responses.size();
      end
   end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import iia_pkg::*;

   localparam int CAPACITY  = 64;
   localparam int WORD_BITS = 32;
   localparam logic [TYPE_BITS-1:0] REQ_UNUSED = 3'd7;

   logic                  clock;
   logic                  reset;
   logic [COUNT_BITS-1:0] held_count;
   int                    mismatches;
   int                    outstanding;
   int                    send_idle_pct;
   int                    stall_pct;
   bit                    growing;

   iia_req_if req_ch ();
   iia_rsp_if rsp_ch ();

   indexed_insert_remove_array #(
      .CAPACITY  (CAPACITY),
      .WORD_BITS (WORD_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   insert_remove_checker #(
      .CAPACITY  (CAPACITY),
      .WORD_BITS (WORD_BITS)
   ) checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .held_count  (held_count),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic send_item(input logic [TYPE_BITS-1:0] code, input logic [POS_BITS-1:0] pos,
                            input logic [VALUE_BITS-1:0] word);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= code;
      req_ch.position <= pos;
      req_ch.value    <= word;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic send_random();
      logic [TYPE_BITS-1:0]  code;
      logic [POS_BITS-1:0]   pos;
      logic [VALUE_BITS-1:0] word;
      int                    held;
      int                    roll;
      held = int'(held_count);
      if (held == CAPACITY && $urandom_range(0, 3) == 0) begin
         growing = 1'b0;
      end else if (held == 0 && $urandom_range(0, 3) == 0) begin
         growing = 1'b1;
      end else if ($urandom_range(0, 59) == 0) begin
         growing = !growing;
      end
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         code = TYPE_BITS'($urandom_range(0, 7));
      end else if (roll < 20) begin
         code = REQ_READ;
      end else if (growing ? roll < 80 : roll < 35) begin
         case ($urandom_range(0, 2))
            0: code = REQ_ADD_END;
            1: code = REQ_ADD_START;
            default: code = REQ_INSERT;
         endcase
      end else begin
         case ($urandom_range(0, 2))
            0: code = REQ_REMOVE_END;
            1: code = REQ_REMOVE_START;
            default: code = REQ_REMOVE_AT;
         endcase
      end
      if ($urandom_range(0, 4) == 0) begin
         pos = POS_BITS'($urandom_range(0, CAPACITY));
      end else if (code == REQ_INSERT) begin
         pos = POS_BITS'($urandom_range(0, held));
      end else begin
         pos = (held > 0) ? POS_BITS'($urandom_range(0, held - 1)) : '0;
      end
      case ($urandom_range(0, 9))
         0: word = '0;
         1: word = '1;
         default: word = $urandom;
      endcase
      send_item(code, pos, word);
   endtask

   initial begin
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.req_type = '0;
      req_ch.position = '0;
      req_ch.value    = '0;
      send_idle_pct   = 0;
      stall_pct       = 0;
      growing         = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_item(REQ_READ, 7'd0, 32'h0);
      send_item(REQ_REMOVE_END, 7'd0, 32'h0);
      send_item(REQ_REMOVE_START, 7'd0, 32'h0);
      send_item(REQ_REMOVE_AT, 7'd0, 32'h0);
      send_item(REQ_INSERT, 7'd1, 32'h1234_5678);
      send_item(REQ_ADD_END, 7'd0, 32'hFFFF_FFFF);
      send_item(REQ_ADD_START, 7'd64, 32'h0000_0000);
      send_item(REQ_INSERT, 7'd1, 32'hA5A5_A5A5);
      send_item(REQ_INSERT, 7'd3, 32'h5A5A_5A5A);
      send_item(REQ_INSERT, 7'd64, 32'hDEAD_BEEF);
      send_item(REQ_READ, 7'd0, 32'hFFFF_FFFF);
      send_item(REQ_READ, 7'd1, 32'h0);
      send_item(REQ_READ, 7'd2, 32'h0);
      send_item(REQ_READ, 7'd3, 32'h0);
      send_item(REQ_READ, 7'd4, 32'h0);
      send_item(REQ_READ, 7'd64, 32'h0);
      send_item(REQ_UNUSED, 7'd127, 32'hFFFF_FFFF);
      send_item(REQ_REMOVE_AT, 7'd4, 32'h0);
      send_item(REQ_REMOVE_AT, 7'd1, 32'h0);
      send_item(REQ_REMOVE_START, 7'd0, 32'h0);
      send_item(REQ_REMOVE_END, 7'd0, 32'h0);
      send_item(REQ_READ, 7'd0, 32'h0);
      send_item(REQ_REMOVE_AT, 7'd0, 32'h0);
      send_item(REQ_REMOVE_END, 7'd0, 32'h0);

      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 57;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 57;
            end
            default: begin
               send_idle_pct = 28;
               stall_pct     = 28;
            end
         endcase
         repeat (250) send_random();
      end
      req_ch.valid <= 1'b0;

      wait (outstanding == 0);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/iia_pkg.sv
design/iia_req_if.sv
design/iia_rsp_if.sv
design/iia_cell.sv
design/iia_ctrl.sv
design/indexed_insert_remove_array.sv
tb/sv/insert_remove_checker.sv
tb/sv/testbench.sv
